### hdl/enig_pkg.sv
// Shared types, constants and letter arithmetic for the three-rotor cipher.
package enig_pkg;

	localparam int ALPHA = 26;
	localparam int LETTER_W = 5;
	localparam int NUM_CELLS = 7;
	localparam int STAGE_W = 3;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [STAGE_W-1:0] stage_t;

	typedef struct packed {
		letter_t fast;
		letter_t middle;
		letter_t slow;
	} pos_t;

	localparam letter_t LAST_LETTER = letter_t'(ALPHA - 1);

	// Wiring of the seven passes in signal order: fast, middle, slow rotor,
	// reflector, then the return through slow, middle and fast.
	localparam logic [ALPHA*8-1:0] WIRING [NUM_CELLS] = '{
		"BDFHJLCPRTXVZNYEIWGAKMUSQO",
		"AJDKSIRUXBLHWTMCQGZNPYFVOE",
		"EKMFLGDQVZNTOWYHXUSPAIBRCJ",
		"IXUHFEZDAOMTKQJWNSRLCYPBVG",
		"UWYGADFPVZBECKMTHXSLRINQOJ",
		"AJPCZWRLFBDKOTYUQGENHXMIVS",
		"TAGBPCSDQEUFVNZHYIXJWLRKOM"
	};

	// Sum of two letters, reduced once since both are below the alphabet size.
	function automatic letter_t add_mod(letter_t a, letter_t b);
		logic [LETTER_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (LETTER_W+1)'(ALPHA)) begin
			sum = sum - (LETTER_W+1)'(ALPHA);
		end
		return sum[LETTER_W-1:0];
	endfunction

	function automatic letter_t sub_mod(letter_t a, letter_t b);
		letter_t diff;
		if (a >= b) begin
			diff = a - b;
		end else begin
			diff = letter_t'(ALPHA) - (b - a);
		end
		return diff;
	endfunction

	// The leftmost character of each wiring string sits at the top bits.
	function automatic letter_t wire_sub(stage_t stage, letter_t idx);
		logic [7:0] base;
		logic [7:0] ch;
		base = 8'(LAST_LETTER - idx) << 3;
		ch = WIRING[stage][base +: 8];
		return letter_t'(ch - 8'd65);
	endfunction

	// The reflector stands still; the other passes use their rotor's position.
	function automatic letter_t offset_sel(stage_t stage, pos_t pos);
		letter_t off;
		unique case (stage)
			3'd0, 3'd6: off = pos.fast;
			3'd1, 3'd5: off = pos.middle;
			3'd2, 3'd4: off = pos.slow;
			default:    off = '0;
		endcase
		return off;
	endfunction

endpackage

### hdl/enig_odometer.sv
// Rotor position odometer that steps once for each accepted letter.
module enig_odometer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           new_message,
	output enig_pkg::pos_t next_pos
);

	enig_pkg::pos_t pos_q;

	always_comb begin
		next_pos = pos_q;
		if (new_message) begin
			next_pos.fast = enig_pkg::letter_t'(1);
			next_pos.middle = '0;
			next_pos.slow = '0;
		end else if (pos_q.fast != enig_pkg::LAST_LETTER) begin
			next_pos.fast = pos_q.fast + enig_pkg::letter_t'(1);
		end else begin
			next_pos.fast = '0;
			if (pos_q.middle != enig_pkg::LAST_LETTER) begin
				next_pos.middle = pos_q.middle + enig_pkg::letter_t'(1);
			end else begin
				next_pos.middle = '0;
				if (pos_q.slow != enig_pkg::LAST_LETTER) begin
					next_pos.slow = pos_q.slow + enig_pkg::letter_t'(1);
				end else begin
					next_pos.slow = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (step) begin
			pos_q <= next_pos;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q.fast <= enig_pkg::LAST_LETTER && pos_q.middle <= enig_pkg::LAST_LETTER &&
		pos_q.slow <= enig_pkg::LAST_LETTER)
		else $error("rotor position out of range");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && new_message |=> pos_q.fast == enig_pkg::letter_t'(1) &&
		pos_q.middle == '0 && pos_q.slow == '0)
		else $error("new message did not restart the rotors");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pos_q))
		else $error("rotors moved without a letter");

endmodule

### hdl/enig_cell.sv
// One substitution pass of the cipher chain, registered at its output.
module enig_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  enig_pkg::stage_t  stage,
	input  logic              in_valid,
	input  enig_pkg::letter_t in_letter,
	input  enig_pkg::pos_t    in_pos,
	output logic              out_valid,
	output enig_pkg::letter_t out_letter,
	output enig_pkg::pos_t    out_pos
);

	enig_pkg::letter_t off;
	enig_pkg::letter_t idx;
	enig_pkg::letter_t sub;
	enig_pkg::letter_t res;
	logic              valid_s1;
	enig_pkg::letter_t letter_s1;
	enig_pkg::pos_t    pos_s1;

	// Shift into the rotor frame, go through the wiring, shift back out.
	always_comb begin
		off = enig_pkg::offset_sel(stage, in_pos);
		idx = enig_pkg::add_mod(in_letter, off);
		sub = enig_pkg::wire_sub(stage, idx);
		res = enig_pkg::sub_mod(sub, off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			letter_s1 <= res;
			pos_s1 <= in_pos;
		end
	end

	assign out_valid = valid_s1;
	assign out_letter = letter_s1;
	assign out_pos = pos_s1;

endmodule

### hdl/three_rotor_enigma_cipher.sv
// Top level of the three-rotor letter cipher: odometer and chain of seven passes.
//
// Letters enter on the plain channel (plain_valid, plain_ready, plain_letter,
// new_message) and leave on the cipher channel (cipher_valid, cipher_ready,
// cipher_letter). Each channel moves one letter per transaction when its valid
// and ready are both high at a rising clock edge.
// A letter of 26 to 31 is folded down by 26 before it is enciphered.
// The rotor odometer steps at the accepting edge, so each letter carries its
// own rotor positions down the chain with it. Setting new_message restarts the
// count, and that letter is enciphered with the fast rotor at position one.
// The chain holds seven cells: fast, middle and slow rotor, reflector, then
// the slow, middle and fast rotors in reverse. Each cell is one register stage,
// and the last cell's register drives the cipher channel directly. A letter is
// registered in each cell in turn before it shows on cipher_valid. One letter
// can be accepted in every cycle while the output is not stalled, so the
// sustained rate is one letter per clock.
// When the receiver holds cipher_ready low with a result waiting, the whole
// chain freezes and plain_ready falls; bubbles do not close up but move down the chain.
// Asynchronous reset empties the chain and zeroes all three rotor positions, so
// the first letter after reset uses the same positions as one sent with new_message.
module three_rotor_enigma_cipher (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      plain_valid,
	output logic                      plain_ready,
	input  logic [4:0]                plain_letter,
	input  logic                      new_message,
	output logic                      cipher_valid,
	input  logic                      cipher_ready,
	output logic [4:0]                cipher_letter
);

	logic              en;
	logic              accept;
	enig_pkg::letter_t folded;
	enig_pkg::pos_t    next_pos;

	// Link k feeds cell k; link NUM_CELLS is the output register.
	logic              valid_c  [enig_pkg::NUM_CELLS+1];
	enig_pkg::letter_t letter_c [enig_pkg::NUM_CELLS+1];
	enig_pkg::pos_t    pos_c    [enig_pkg::NUM_CELLS+1];

	// The chain advances whenever the output register is empty or being read.
	assign en = !cipher_valid || cipher_ready;
	assign plain_ready = en;
	assign accept = plain_valid && en;

	assign folded = (plain_letter >= enig_pkg::letter_t'(enig_pkg::ALPHA)) ?
		plain_letter - enig_pkg::letter_t'(enig_pkg::ALPHA) : plain_letter;

	enig_odometer u_odometer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.new_message (new_message),
		.next_pos    (next_pos)
	);

	assign valid_c[0] = plain_valid;
	assign letter_c[0] = folded;
	assign pos_c[0] = next_pos;

	for (genvar k = 0; k < enig_pkg::NUM_CELLS; k++) begin : g_cell
		enig_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.stage      (enig_pkg::stage_t'(k)),
			.in_valid   (valid_c[k]),
			.in_letter  (letter_c[k]),
			.in_pos     (pos_c[k]),
			.out_valid  (valid_c[k+1]),
			.out_letter (letter_c[k+1]),
			.out_pos    (pos_c[k+1])
		);
	end

	assign cipher_valid = valid_c[enig_pkg::NUM_CELLS];
	assign cipher_letter = letter_c[enig_pkg::NUM_CELLS];

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid |-> cipher_letter <= enig_pkg::LAST_LETTER)
		else $error("cipher letter out of range");

	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_c[3]) && $stable(letter_c[3]))
		else $error("chain moved while the output was stalled");

	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && !cipher_ready |-> !accept)
		else $error("letter accepted while the output was stalled");

endmodule
